[rtl/rsi_pkg.sv]
package rsi_pkg;

  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_t;

  // Hit count codes
  localparam logic [1:0] HIT_NONE    = 2'd0;
  localparam logic [1:0] HIT_TANGENT = 2'd1;
  localparam logic [1:0] HIT_TWO     = 2'd2;

  // Control that travels alongside the data of one ray
  typedef struct packed {
    logic       valid;
    logic [1:0] hit_count;
  } rsi_ctl_t;

endpackage

[rtl/rsi_if.sv]
interface rsi_ray_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] origin_x;
  logic signed [DATA_WIDTH-1:0] origin_y;
  logic signed [DATA_WIDTH-1:0] origin_z;
  logic signed [DATA_WIDTH-1:0] dir_x;
  logic signed [DATA_WIDTH-1:0] dir_y;
  logic signed [DATA_WIDTH-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rsi_hit_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   hit_count;
  logic signed [DATA_WIDTH-1:0] t_near;
  logic signed [DATA_WIDTH-1:0] t_far;

  modport source (output valid, hit_count, t_near, t_far, input ready);
  modport sink (input valid, hit_count, t_near, t_far, output ready);
endinterface

[rtl/ray_sphere_intersect_top.sv]
// Ray/sphere intersection, one ray per clock unless the hit channel stalls.
// Each ray transaction on the ray channel (origin and direction, signed
// fixed point with FRAC_BITS fraction bits) yields exactly one transaction
// on the hit channel, in order: hit_count 0 for a miss or a zero direction,
// 1 for a tangent ray, 2 for a ray that enters and leaves the sphere; t_near
// and t_far are the hit distances in units of the direction length, rounded
// toward minus infinity and saturated to the signed DATA_WIDTH range (both
// zero on a miss, equal on a tangent hit). A front end forms the exact
// discriminant, a row of one cell per root bit takes the integer square
// root, the numerators follow, a row of one cell per quotient bit performs
// both divisions, then rounding and saturation and the output register.
// The user writes the sphere center and radius through the cfg port only
// while no ray is in flight; the block does not enforce it. Reset leaves a
// unit sphere at the origin.
module ray_sphere_intersect_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [rsi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]           cfg_data,
  rsi_ray_if.sink                         ray,
  rsi_hit_if.source                       hit
);
  import rsi_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int W1  = W + 1;
  localparam int AW  = 2 * W;           // a = D.D, unsigned
  localparam int BW  = 2 * W + 2;       // b = D.E, signed
  localparam int SQN = 2 * W + 2;       // root bits
  localparam int RW  = 2 * SQN;         // square root operand
  localparam int SW  = AW + BW;         // side data through the root row
  localparam int NW  = 2 * W + 4;       // signed numerator -b +/- s
  localparam int MW  = 2 * W + 3;       // numerator magnitude
  localparam int NM  = MW + F;          // magnitude scaled by the fraction bits
  localparam int RMW = AW + W;          // divider remainder
  localparam int XW  = (NM > RMW) ? NM : RMW;
  localparam int DSW = 4;               // near/far sign and overflow flags

  localparam logic [W-2:0] RADIUS_ONE = {{(W-2){1'b0}}, 1'b1} << F;

  // Configuration registers
  logic signed [W-1:0] center_x, center_y, center_z;
  logic [W-2:0]        radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      radius   <= RADIUS_ONE;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: center_x <= $signed(cfg_data);
        REG_CENTER_Y: center_y <= $signed(cfg_data);
        REG_CENTER_Z: center_z <= $signed(cfg_data);
        REG_RADIUS:   radius   <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // The whole pipe advances together; it holds only while the skid
  // register is occupied, so ready comes straight from a flop.
  logic skid_valid;
  logic en;

  assign en        = !skid_valid;
  assign ray.ready = en;

  // Discriminant front end
  rsi_ctl_t             dc_ctl;
  logic [AW-1:0]        dc_a;
  logic signed [BW-1:0] dc_b;
  logic [RW-1:0]        dc_rad;

  rsi_disc #(
    .DATA_WIDTH (W)
  ) u_disc (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (ray.valid),
    .origin_x (ray.origin_x),
    .origin_y (ray.origin_y),
    .origin_z (ray.origin_z),
    .dir_x    (ray.dir_x),
    .dir_y    (ray.dir_y),
    .dir_z    (ray.dir_z),
    .center_x (center_x),
    .center_y (center_y),
    .center_z (center_z),
    .radius   (radius),
    .ctl      (dc_ctl),
    .a        (dc_a),
    .b        (dc_b),
    .rad      (dc_rad)
  );

  // Square root row: one cell per root bit
  rsi_ctl_t      sq_ctl  [SQN+1];
  logic [RW-1:0] sq_rem  [SQN+1];
  logic [RW-1:0] sq_root [SQN+1];
  logic [SW-1:0] sq_side [SQN+1];

  assign sq_ctl[0]  = dc_ctl;
  assign sq_rem[0]  = dc_rad;
  assign sq_root[0] = '0;
  assign sq_side[0] = {dc_a, dc_b};

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    rsi_sqrt_cell #(
      .RW   (RW),
      .STEP (k),
      .SW   (SW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (sq_ctl[k]),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .side_in  (sq_side[k]),
      .ctl_out  (sq_ctl[k+1]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1]),
      .side_out (sq_side[k+1])
    );
  end

  logic [AW-1:0]        sq_a;
  logic signed [BW-1:0] sq_b;
  logic [SQN-1:0]       sq_s;

  assign sq_a = sq_side[SQN][SW-1:BW];
  assign sq_b = $signed(sq_side[SQN][BW-1:0]);
  assign sq_s = sq_root[SQN][SQN-1:0];

  // Numerators -b - s and -b + s
  rsi_ctl_t             n1_ctl;
  logic [AW-1:0]        n1_a;
  logic signed [NW-1:0] n1_near, n1_far;

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_ctl <= '0;
    end else if (en) begin
      n1_ctl <= sq_ctl[SQN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_a    <= sq_a;
      n1_near <= -NW'(sq_b) - $signed(NW'(sq_s));
      n1_far  <= -NW'(sq_b) + $signed(NW'(sq_s));
    end
  end

  // Sign and magnitude
  rsi_ctl_t             n2_ctl;
  logic [AW-1:0]        n2_a;
  logic                 n2_neg_near, n2_neg_far;
  logic [MW-1:0]        n2_mag_near, n2_mag_far;
  logic signed [NW-1:0] abs_near, abs_far;

  assign abs_near = n1_near[NW-1] ? -n1_near : n1_near;
  assign abs_far  = n1_far[NW-1]  ? -n1_far  : n1_far;

  always_ff @(posedge clk) begin
    if (rst) begin
      n2_ctl <= '0;
    end else if (en) begin
      n2_ctl <= n1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_a        <= n1_a;
      n2_neg_near <= n1_near[NW-1];
      n2_neg_far  <= n1_far[NW-1];
      n2_mag_near <= abs_near[MW-1:0];
      n2_mag_far  <= abs_far[MW-1:0];
    end
  end

  // Scale by the fraction bits; flag quotients that do not fit in W bits
  logic [XW-1:0] sc_near, sc_far, den_top;

  assign sc_near = XW'({n2_mag_near, {F{1'b0}}});
  assign sc_far  = XW'({n2_mag_far, {F{1'b0}}});
  assign den_top = XW'({n2_a, {W{1'b0}}});

  rsi_ctl_t       dv_ctl  [W+1];
  logic [AW-1:0]  dv_den  [W+1];
  logic [RMW-1:0] dv_rem0 [W+1];
  logic [RMW-1:0] dv_rem1 [W+1];
  logic [W-1:0]   dv_quo0 [W+1];
  logic [W-1:0]   dv_quo1 [W+1];
  logic [DSW-1:0] dv_side [W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl[0] <= '0;
    end else if (en) begin
      dv_ctl[0] <= n2_ctl;
    end
  end

  // side = {near negative, far negative, near overflow, far overflow}
  always_ff @(posedge clk) begin
    if (en) begin
      dv_den[0]  <= n2_a;
      dv_rem0[0] <= sc_near[RMW-1:0];
      dv_rem1[0] <= sc_far[RMW-1:0];
      dv_quo0[0] <= '0;
      dv_quo1[0] <= '0;
      dv_side[0] <= {n2_neg_near, n2_neg_far, sc_near >= den_top, sc_far >= den_top};
    end
  end

  // Divider row: one cell per quotient bit, both distances side by side
  for (genvar k = 0; k < W; k++) begin : g_div
    rsi_div_cell #(
      .AW   (AW),
      .QW   (W),
      .STEP (k),
      .SW   (DSW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (dv_ctl[k]),
      .den_in   (dv_den[k]),
      .rem0_in  (dv_rem0[k]),
      .rem1_in  (dv_rem1[k]),
      .quo0_in  (dv_quo0[k]),
      .quo1_in  (dv_quo1[k]),
      .side_in  (dv_side[k]),
      .ctl_out  (dv_ctl[k+1]),
      .den_out  (dv_den[k+1]),
      .rem0_out (dv_rem0[k+1]),
      .rem1_out (dv_rem1[k+1]),
      .quo0_out (dv_quo0[k+1]),
      .quo1_out (dv_quo1[k+1]),
      .side_out (dv_side[k+1])
    );
  end

  // Round a negative quotient toward minus infinity, saturate, apply sign
  function automatic logic [W-1:0] fix_dist(input logic neg, input logic ovf,
                                            input logic [W-1:0] quo,
                                            input logic rem_nz);
    logic [W:0] qq;
    logic [W:0] bound;
    logic [W:0] nq;
    qq    = {1'b0, quo} + W1'(neg && rem_nz);
    bound = neg ? (W1'(1) << (W - 1)) : ((W1'(1) << (W - 1)) - W1'(1));
    if (ovf || (qq > bound)) begin
      qq = bound;
    end
    nq       = -qq;
    fix_dist = neg ? nq[W-1:0] : qq[W-1:0];
  endfunction

  rsi_ctl_t            fin_ctl;
  logic signed [W-1:0] fin_near, fin_far;
  logic                fin_miss;
  logic [DSW-1:0]      fin_side;

  assign fin_side = dv_side[W];
  assign fin_miss = dv_ctl[W].hit_count == HIT_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_ctl <= '0;
    end else if (en) begin
      fin_ctl <= dv_ctl[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_near <= fin_miss ? '0
                : $signed(fix_dist(fin_side[3], fin_side[1], dv_quo0[W], |dv_rem0[W]));
      fin_far  <= fin_miss ? '0
                : $signed(fix_dist(fin_side[2], fin_side[0], dv_quo1[W], |dv_rem1[W]));
    end
  end

  // Output register with a skid stage behind it
  logic                out_valid;
  logic [1:0]          out_hit, skid_hit;
  logic signed [W-1:0] out_near, out_far, skid_near, skid_far;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || hit.ready) begin
      if (skid_valid) begin
        // drain the parked transaction first
        out_valid  <= 1'b1;
        out_hit    <= skid_hit;
        out_near   <= skid_near;
        out_far    <= skid_far;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= fin_ctl.valid;
        out_hit   <= fin_ctl.hit_count;
        out_near  <= fin_near;
        out_far   <= fin_far;
      end
    end else if (fin_ctl.valid && en) begin
      // output stalled: park the arriving transaction
      skid_valid <= 1'b1;
      skid_hit   <= fin_ctl.hit_count;
      skid_near  <= fin_near;
      skid_far   <= fin_far;
    end
  end

  assign hit.valid     = out_valid;
  assign hit.hit_count = out_hit;
  assign hit.t_near    = out_near;
  assign hit.t_far     = out_far;

endmodule

[rtl/rsi_disc.sv]
module rsi_disc #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [DATA_WIDTH-1:0]   origin_x,
  input  logic signed [DATA_WIDTH-1:0]   origin_y,
  input  logic signed [DATA_WIDTH-1:0]   origin_z,
  input  logic signed [DATA_WIDTH-1:0]   dir_x,
  input  logic signed [DATA_WIDTH-1:0]   dir_y,
  input  logic signed [DATA_WIDTH-1:0]   dir_z,
  input  logic signed [DATA_WIDTH-1:0]   center_x,
  input  logic signed [DATA_WIDTH-1:0]   center_y,
  input  logic signed [DATA_WIDTH-1:0]   center_z,
  input  logic [DATA_WIDTH-2:0]          radius,
  output rsi_pkg::rsi_ctl_t              ctl,
  output logic [2*DATA_WIDTH-1:0]        a,
  output logic signed [2*DATA_WIDTH+1:0] b,
  output logic [4*DATA_WIDTH+3:0]        rad
);
  import rsi_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int EW = W + 1;
  localparam int AW = 2 * W;
  localparam int BW = 2 * W + 2;
  localparam int CW = 2 * W + 3;
  localparam int H  = W + 1;
  localparam int PW = 4 * W + 2;
  localparam int DW = 4 * W + 4;

  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dir [3];
  logic signed [W-1:0] cen [3];

  assign org[0] = origin_x;
  assign org[1] = origin_y;
  assign org[2] = origin_z;
  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;
  assign cen[0] = center_x;
  assign cen[1] = center_y;
  assign cen[2] = center_z;

  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v;

  logic signed [W-1:0]   s1_d [3];
  logic signed [EW-1:0]  s1_e [3];
  logic signed [2*W-1:0] s2_dd [3];
  logic signed [2*W:0]   s2_de [3];
  logic signed [2*W+1:0] s2_ee [3];
  logic [2*W-3:0]        s2_rr;
  logic [AW-1:0]         s3_a;
  logic signed [BW-1:0]  s3_b;
  logic signed [CW-1:0]  s3_c;
  logic [AW-1:0]         s4_a;
  logic signed [BW-1:0]  s4_b;
  logic [2*W:0]          s4_bm;
  logic [2*W+1:0]        s4_cm;
  logic                  s4_cneg;
  logic [AW-1:0]         s5_a;
  logic signed [BW-1:0]  s5_b;
  logic                  s5_cneg;
  logic [2*H-1:0]        s5_bll;
  logic [H+W-1:0]        s5_blh;
  logic [2*W-1:0]        s5_bhh;
  logic [2*H-1:0]        s5_all;
  logic [2*H-1:0]        s5_alh;
  logic [W+H-2:0]        s5_ahl;
  logic [2*W-1:0]        s5_ahh;
  logic [AW-1:0]         s6_a;
  logic signed [BW-1:0]  s6_b;
  logic                  s6_cneg;
  logic [PW-1:0]         s6_bb;
  logic [PW-1:0]         s6_ac;
  logic [AW-1:0]         s7_a;
  logic signed [BW-1:0]  s7_b;
  logic signed [DW-1:0]  s7_disc;

  logic signed [BW-1:0] b_abs;
  logic signed [CW-1:0] c_abs;
  logic [1:0]           hit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      s7_v <= 1'b0;
      ctl  <= '0;
    end else if (en) begin
      s1_v          <= in_valid;
      s2_v          <= s1_v;
      s3_v          <= s2_v;
      s4_v          <= s3_v;
      s5_v          <= s4_v;
      s6_v          <= s5_v;
      s7_v          <= s6_v;
      ctl.valid     <= s7_v;
      ctl.hit_count <= hit_next;
    end
  end

  // offset from the center, then the per-axis products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_d[i]  <= dir[i];
        s1_e[i]  <= $signed({org[i][W-1], org[i]}) - $signed({cen[i][W-1], cen[i]});
        s2_dd[i] <= s1_d[i] * s1_d[i];
        s2_de[i] <= s1_d[i] * s1_e[i];
        s2_ee[i] <= s1_e[i] * s1_e[i];
      end
      s2_rr <= radius * radius;
    end
  end

  // a, b, c sums
  always_ff @(posedge clk) begin
    if (en) begin
      s3_a <= {1'b0, s2_dd[0][2*W-2:0]} + {1'b0, s2_dd[1][2*W-2:0]}
            + {1'b0, s2_dd[2][2*W-2:0]};
      s3_b <= BW'(s2_de[0]) + BW'(s2_de[1]) + BW'(s2_de[2]);
      s3_c <= CW'(s2_ee[0]) + CW'(s2_ee[1]) + CW'(s2_ee[2]) - $signed(CW'(s2_rr));
    end
  end

  assign b_abs = s3_b[BW-1] ? -s3_b : s3_b;
  assign c_abs = s3_c[CW-1] ? -s3_c : s3_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_a    <= s3_a;
      s4_b    <= s3_b;
      s4_bm   <= b_abs[2*W:0];
      s4_cm   <= c_abs[2*W+1:0];
      s4_cneg <= s3_c[CW-1];
    end
  end

  // partial products of b*b and a*c on half-width slices
  always_ff @(posedge clk) begin
    if (en) begin
      s5_a    <= s4_a;
      s5_b    <= s4_b;
      s5_cneg <= s4_cneg;
      s5_bll  <= s4_bm[H-1:0] * s4_bm[H-1:0];
      s5_blh  <= s4_bm[H-1:0] * s4_bm[2*W:H];
      s5_bhh  <= s4_bm[2*W:H] * s4_bm[2*W:H];
      s5_all  <= s4_a[H-1:0] * s4_cm[H-1:0];
      s5_alh  <= s4_a[H-1:0] * s4_cm[2*W+1:H];
      s5_ahl  <= s4_a[AW-1:H] * s4_cm[H-1:0];
      s5_ahh  <= s4_a[AW-1:H] * s4_cm[2*W+1:H];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_a    <= s5_a;
      s6_b    <= s5_b;
      s6_cneg <= s5_cneg;
      s6_bb   <= (PW'(s5_bhh) << (2 * H)) + (PW'(s5_blh) << (H + 1)) + PW'(s5_bll);
      s6_ac   <= (PW'(s5_ahh) << (2 * H)) + ((PW'(s5_alh) + PW'(s5_ahl)) << H)
               + PW'(s5_all);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_a    <= s6_a;
      s7_b    <= s6_b;
      s7_disc <= s6_cneg ? $signed(DW'(s6_bb) + DW'(s6_ac))
                         : $signed(DW'(s6_bb) - DW'(s6_ac));
    end
  end

  // classify: zero direction or negative discriminant is a miss
  always_comb begin
    if ((s7_a == '0) || s7_disc[DW-1]) begin
      hit_next = HIT_NONE;
    end else if (s7_disc == '0) begin
      hit_next = HIT_TANGENT;
    end else begin
      hit_next = HIT_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a   <= s7_a;
      b   <= s7_b;
      rad <= (hit_next == HIT_TWO) ? DW'(s7_disc) : '0;
    end
  end

endmodule

[rtl/rsi_sqrt_cell.sv]
module rsi_sqrt_cell #(
  parameter int RW   = 132,
  parameter int STEP = 0,
  parameter int SW   = 130
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rsi_pkg::rsi_ctl_t ctl_in,
  input  logic [RW-1:0]     rem_in,
  input  logic [RW-1:0]     root_in,
  input  logic [SW-1:0]     side_in,
  output rsi_pkg::rsi_ctl_t ctl_out,
  output logic [RW-1:0]     rem_out,
  output logic [RW-1:0]     root_out,
  output logic [SW-1:0]     side_out
);
  import rsi_pkg::*;

  // weight of the root bit settled in this cell
  localparam logic [RW-1:0] BIT = {{(RW-1){1'b0}}, 1'b1} << (RW - 2 - 2 * STEP);

  logic [RW-1:0] trial;
  logic          take;

  assign trial = root_in + BIT;
  assign take  = rem_in >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= take ? rem_in - trial : rem_in;
      root_out <= take ? (root_in >> 1) + BIT : root_in >> 1;
      side_out <= side_in;
    end
  end

endmodule

[rtl/rsi_div_cell.sv]
module rsi_div_cell #(
  parameter int AW   = 64,
  parameter int QW   = 32,
  parameter int STEP = 0,
  parameter int SW   = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rsi_pkg::rsi_ctl_t ctl_in,
  input  logic [AW-1:0]     den_in,
  input  logic [AW+QW-1:0]  rem0_in,
  input  logic [AW+QW-1:0]  rem1_in,
  input  logic [QW-1:0]     quo0_in,
  input  logic [QW-1:0]     quo1_in,
  input  logic [SW-1:0]     side_in,
  output rsi_pkg::rsi_ctl_t ctl_out,
  output logic [AW-1:0]     den_out,
  output logic [AW+QW-1:0]  rem0_out,
  output logic [AW+QW-1:0]  rem1_out,
  output logic [QW-1:0]     quo0_out,
  output logic [QW-1:0]     quo1_out,
  output logic [SW-1:0]     side_out
);
  import rsi_pkg::*;

  localparam int RMW = AW + QW;
  localparam int Q   = QW - 1 - STEP;

  logic [RMW-1:0] dsh;
  logic           take0, take1;
  logic [QW-1:0]  quo0_next, quo1_next;

  assign dsh   = {{QW{1'b0}}, den_in} << Q;
  assign take0 = rem0_in >= dsh;
  assign take1 = rem1_in >= dsh;

  always_comb begin
    quo0_next    = quo0_in;
    quo1_next    = quo1_in;
    quo0_next[Q] = take0;
    quo1_next[Q] = take1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_out  <= den_in;
      rem0_out <= take0 ? rem0_in - dsh : rem0_in;
      rem1_out <= take1 ? rem1_in - dsh : rem1_in;
      quo0_out <= quo0_next;
      quo1_out <= quo1_next;
      side_out <= side_in;
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import rsi_pkg::*;

  localparam int DW       = 32;
  localparam int FB       = 16;
  localparam int LATENCY  = 3 * DW + 15;
  localparam int SETTLE   = LATENCY + 20;
  localparam int WW       = 192;   // wide enough for the exact discriminant

  typedef logic signed [WW-1:0] wide_t;
  typedef logic signed [DW-1:0] fix_t;

  typedef struct packed {
    fix_t origin_x;
    fix_t origin_y;
    fix_t origin_z;
    fix_t dir_x;
    fix_t dir_y;
    fix_t dir_z;
  } ray_t;

  typedef struct packed {
    logic [1:0] hit_count;
    fix_t       t_near;
    fix_t       t_far;
  } hit_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_wen = 1'b0;
  logic [1:0]    cfg_index = REG_CENTER_X;
  logic [DW-1:0] cfg_data = '0;

  rsi_ray_if #(.DATA_WIDTH(DW)) ray_ch ();
  rsi_hit_if #(.DATA_WIDTH(DW)) hit_ch ();

  ray_sphere_intersect_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ray       (ray_ch),
    .hit       (hit_ch)
  );

  // Our own copy of the sphere registers, tracking every write we issue
  fix_t        sph_cx = '0, sph_cy = '0, sph_cz = '0;
  logic [30:0] sph_r  = 31'd65536;

  hit_t pending_hits[$];
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  int   n_rays = 0, n_checked = 0, n_errors = 0;
  int   n_miss = 0, n_tangent = 0, n_two = 0;

  always #5 clk = ~clk;

  // Receiver: stall at random according to the current pressure setting
  always @(posedge clk) begin
    hit_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Ray channel starts idle with known payload
  initial begin
    ray_ch.valid    = 1'b0;
    ray_ch.origin_x = '0;
    ray_ch.origin_y = '0;
    ray_ch.origin_z = '0;
    ray_ch.dir_x    = '0;
    ray_ch.dir_y    = '0;
    ray_ch.dir_z    = '0;
    hit_ch.ready    = 1'b0;
  end

  // Exact integer square root, floor
  function automatic logic [WW-1:0] int_sqrt(input logic [WW-1:0] v);
    logic [WW-1:0] res, bitv;
    res  = '0;
    bitv = {2'b01, {(WW-2){1'b0}}};
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // floor(num * 2^FB / den), den positive, clamped to the signed DW range
  function automatic fix_t scaled_distance(input wide_t num, input wide_t den);
    wide_t n, q;
    wide_t hi_lim, lo_lim;
    n      = num <<< FB;
    q      = n / den;
    if (n < 0 && (n % den) != 0) q = q - 1;
    hi_lim = (wide_t'(1) <<< (DW - 1)) - 1;
    lo_lim = -(wide_t'(1) <<< (DW - 1));
    if (q > hi_lim) q = hi_lim;
    if (q < lo_lim) q = lo_lim;
    return fix_t'(q);
  endfunction

  function automatic wide_t widen(input fix_t v);
    return v;
  endfunction

  // Expected hit for one ray against the current sphere
  function automatic hit_t intersect_sphere(input ray_t r);
    wide_t dx, dy, dz, ex, ey, ez;
    wide_t qa, qb, qc, rr, disc;
    wide_t root;
    hit_t  h;
    dx = widen(r.dir_x);
    dy = widen(r.dir_y);
    dz = widen(r.dir_z);
    ex = widen(r.origin_x) - widen(sph_cx);
    ey = widen(r.origin_y) - widen(sph_cy);
    ez = widen(r.origin_z) - widen(sph_cz);
    rr = $signed({1'b0, sph_r});
    qa = dx * dx + dy * dy + dz * dz;
    qb = dx * ex + dy * ey + dz * ez;
    qc = ex * ex + ey * ey + ez * ez - rr * rr;
    h  = '{HIT_NONE, '0, '0};
    if (qa == 0) return h;
    disc = qb * qb - qa * qc;
    if (disc == 0) begin
      h.hit_count = HIT_TANGENT;
      h.t_near    = scaled_distance(-qb, qa);
      h.t_far     = h.t_near;
    end else if (disc > 0) begin
      root        = $signed(int_sqrt(disc));
      h.hit_count = HIT_TWO;
      h.t_near    = scaled_distance(-qb - root, qa);
      h.t_far     = scaled_distance(-qb + root, qa);
    end
    return h;
  endfunction

  // Compare every hit transaction against the oldest expectation
  always @(posedge clk) begin
    hit_t want;
    if (!rst && hit_ch.valid && hit_ch.ready) begin
      if (pending_hits.size() == 0) begin
        $error("hit transaction with no ray outstanding");
        n_errors++;
      end else begin
        want = pending_hits.pop_front();
        n_checked++;
        if (hit_ch.hit_count !== want.hit_count) begin
          $error("hit_count: expected %0d, got %0d", want.hit_count, hit_ch.hit_count);
          n_errors++;
        end
        if (hit_ch.t_near !== want.t_near) begin
          $error("t_near: expected %0d, got %0d", want.t_near, hit_ch.t_near);
          n_errors++;
        end
        if (hit_ch.t_far !== want.t_far) begin
          $error("t_far: expected %0d, got %0d", want.t_far, hit_ch.t_far);
          n_errors++;
        end
      end
    end
  end

  // Send one ray; valid stays high into the next call unless the sender idles
  task automatic send_ray(input ray_t r);
    hit_t h;
    while ($urandom_range(99) < src_idle_pct) begin
      ray_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ray_ch.valid    <= 1'b1;
    ray_ch.origin_x <= r.origin_x;
    ray_ch.origin_y <= r.origin_y;
    ray_ch.origin_z <= r.origin_z;
    ray_ch.dir_x    <= r.dir_x;
    ray_ch.dir_y    <= r.dir_y;
    ray_ch.dir_z    <= r.dir_z;
    do @(posedge clk); while (!ray_ch.ready);
    h = intersect_sphere(r);
    pending_hits.insert(pending_hits.size(), h);
    n_rays++;
    case (h.hit_count)
      HIT_NONE:    n_miss++;
      HIT_TANGENT: n_tangent++;
      default:     n_two++;
    endcase
  endtask

  // Drop valid and hold until every outstanding ray has come back
  task automatic drain_hits();
    ray_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  // Reprogram the sphere; only done with nothing in flight
  task automatic load_sphere(input fix_t cx, input fix_t cy, input fix_t cz,
                             input logic [DW-1:0] radius);
    drain_hits();
    repeat (SETTLE) @(posedge clk);
    cfg_wen <= 1'b1; cfg_index <= REG_CENTER_X; cfg_data <= cx;
    @(posedge clk);
    cfg_index <= REG_CENTER_Y; cfg_data <= cy;
    @(posedge clk);
    cfg_index <= REG_CENTER_Z; cfg_data <= cz;
    @(posedge clk);
    cfg_index <= REG_RADIUS; cfg_data <= radius;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sph_cx = cx;
    sph_cy = cy;
    sph_cz = cz;
    sph_r  = radius[30:0];
  endtask

  function automatic ray_t mk_ray(input longint ox, oy, oz, dx, dy, dz);
    ray_t r;
    r.origin_x = fix_t'(ox);
    r.origin_y = fix_t'(oy);
    r.origin_z = fix_t'(oz);
    r.dir_x    = fix_t'(dx);
    r.dir_y    = fix_t'(dy);
    r.dir_z    = fix_t'(dz);
    return r;
  endfunction

  function automatic longint small_val();
    return longint'($urandom_range(2 * 65536 * 16)) - 65536 * 16;
  endfunction

  // Mostly rays aimed at the sphere from nearby, plus raw noise
  function automatic ray_t random_ray();
    longint span, o[3], tg[3], c[3];
    int     sh, pick;
    ray_t   r;
    pick = $urandom_range(9);
    if (pick < 2)
      return ray_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if (pick < 3)
      return mk_ray(small_val(), small_val(), small_val(),
                    small_val(), small_val(), small_val());
    c[0] = sph_cx; c[1] = sph_cy; c[2] = sph_cz;
    span = longint'(sph_r) + 65536;
    sh   = $urandom_range(12);
    for (int i = 0; i < 3; i++) begin
      o[i]  = c[i] + (longint'($urandom_range(8 * 65536)) - 4 * 65536) * (span >>> 16)
              + longint'($urandom_range(1023)) - 512;
      tg[i] = c[i] + ((longint'($urandom) - 64'sh80000000) % (span + 1));
    end
    return mk_ray(o[0], o[1], o[2], (tg[0] - o[0]) >>> sh, (tg[1] - o[1]) >>> sh,
                  (tg[2] - o[2]) >>> sh);
  endfunction

  // Extremes, zero direction, tangent, two hits, saturation both ways
  task automatic test_directed_rays();
    longint one = 65536;
    send_ray(mk_ray(-5 * one, 0, 0, one, 0, 0));           // enter and exit
    send_ray(mk_ray(-5 * one, one, 0, one, 0, 0));         // grazes the surface
    send_ray(mk_ray(-5 * one, 2 * one, 0, one, 0, 0));     // clean miss
    send_ray(mk_ray(0, 0, 0, 0, 0, 0));                    // no direction
    send_ray(mk_ray(3 * one, 0, 0, 0, 0, 0));
    send_ray(mk_ray(0, 0, 0, 0, -one, 0));                 // from inside
    send_ray(mk_ray(5 * one, 0, 0, one, 0, 0));            // sphere behind the ray
    send_ray(mk_ray(-100 * one, 0, 0, 1, 0, 0));           // positive overflow
    send_ray(mk_ray(100 * one, 0, 0, 1, 0, 0));            // negative overflow
    send_ray(mk_ray(0, 0, -3 * one, 0, 0, 1));
    send_ray(mk_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_ray(mk_ray(-64'sh80000000, -64'sh80000000, -64'sh80000000,
                    -64'sh80000000, -64'sh80000000, -64'sh80000000));
    send_ray(mk_ray(32'h7fffffff, 0, 0, -64'sh80000000, 0, 0));
    send_ray(mk_ray(-64'sh80000000, 0, 0, 32'h7fffffff, 0, 0));
    send_ray(mk_ray(-3 * one, -3 * one, -3 * one, one, one, one));
    send_ray(mk_ray(0, 0, 0, 1, 1, 1));
    send_ray(mk_ray(-1, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    drain_hits();                                         // sender waits for all hits
  endtask

  // Sphere registers at their extremes, then a point sphere
  task automatic test_extreme_sphere();
    load_sphere(32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff);
    send_ray(mk_ray(0, 0, 0, 32'h7fffffff, 32'h80000000, 0));
    send_ray(mk_ray(32'h7fffffff, 32'h80000000, 0, 0, 0, 65536));
    send_ray(mk_ray(32'h80000000, 32'h7fffffff, 32'h7fffffff, 1, 0, 0));
    load_sphere(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0);
    send_ray(mk_ray(32'h80000000, 32'h7fffffff, 32'h80000000 + 65536, 0, 0, -65536));
    send_ray(mk_ray(32'h80000000 + 65536, 32'h7fffffff, 32'h80000000, 65536, 0, 0));
    drain_hits();
  endtask

  task automatic test_random_rays(input int count);
    repeat (count) send_ray(random_ray());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase 1: sender rarely idles, receiver stalls heavily
    src_idle_pct  = 10;
    snk_stall_pct = 86;
    test_directed_rays();
    test_random_rays(160);
    test_extreme_sphere();

    // Phase 2: sender idles heavily, receiver rarely stalls
    src_idle_pct  = 86;
    snk_stall_pct = 10;
    load_sphere(32'sh00038000, -32'sh00020000, 32'sh000a0000, 32'h00054000);
    test_random_rays(160);

    // Phase 3: full rate both ways
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    load_sphere(-32'sh00640000, 32'sh00001234, 32'sh01000000, 32'h01000000);
    test_random_rays(150);
    load_sphere(32'sh00001000, -32'sh00000100, 32'sh0, 32'h00000010);
    test_random_rays(150);

    drain_hits();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d rays over six sphere settings under mixed back-pressure:",
             n_rays);
    $display("  %0d misses, %0d tangent hits, %0d two-hit rays, %0d hits checked",
             n_miss, n_tangent, n_two, n_checked);
    if (n_errors == 0 && pending_hits.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
